// ===== hdl/arpc_pkg.sv =====
// Package for the ARP cache resolver: transaction types, codes and constants.
`default_nettype none
package arpc_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 8;

  // Configuration port: 64-bit data, registers on 8-byte boundaries.
  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 5;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_OWN_MAC     = 2'd0;
  localparam reg_idx_t REG_SUBNET_ADDR = 2'd1;
  localparam reg_idx_t REG_SUBNET_MASK = 2'd2;
  localparam reg_idx_t REG_ROUTER_IP   = 2'd3;

  localparam logic [1:0] FUNC_RX      = 2'd0;
  localparam logic [1:0] FUNC_RESOLVE = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IP   = 16'h0800;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_REPLY   = 3'd1;
  localparam logic [2:0] ACT_REQUEST = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_DELIVER = 3'd4;

  localparam logic [31:0] BCAST_IP  = 32'hFFFF_FFFF;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] frame_type;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] dest_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] dest_mac;
    logic [31:0] request_ip;
  } out_item_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] subnet_addr;
    logic [31:0] subnet_mask;
    logic [31:0] router_ip;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  stamp;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/arpc_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module arpc_regs
  import arpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:3];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_OWN_MAC:     cfg_q.own_mac     <= pwdata[47:0];
        REG_SUBNET_ADDR: cfg_q.subnet_addr <= pwdata[31:0];
        REG_SUBNET_MASK: cfg_q.subnet_mask <= pwdata[31:0];
        REG_ROUTER_IP:   cfg_q.router_ip   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OWN_MAC:     prdata = {16'd0, cfg_q.own_mac};
      REG_SUBNET_ADDR: prdata = {32'd0, cfg_q.subnet_addr};
      REG_SUBNET_MASK: prdata = {32'd0, cfg_q.subnet_mask};
      REG_ROUTER_IP:   prdata = {32'd0, cfg_q.router_ip};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/arpc_table.sv =====
// Entry memory: registered synchronous read, valid bits give the cleared reset state.
`default_nettype none
module arpc_table
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W         = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  entry_t                wr_data_i,
  output entry_t                rd_data_o
);

  entry_t                   mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  entry_t                   rd_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // never-written entries read as all zero (free)
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== hdl/arpc_ctrl.sv =====
// Sequencer: decodes a transaction, scans the table, writes back and registers the result.
`default_nettype none
module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W         = 3,
  parameter int unsigned CNT_W         = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  output logic                  rd_en_o,
  output logic      [IDX_W-1:0] rd_addr_o,
  input  entry_t                rd_data_i,
  output logic                  wr_en_o,
  output logic      [IDX_W-1:0] wr_addr_o,
  output entry_t                wr_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_e;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  state_e     state_q, state_d;
  logic [31:0] key_q, key_d;
  logic [47:0] smac_q, smac_d;
  logic        upd_q, upd_d;
  logic        rep_q, rep_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic        rdv_q, rdv_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic        hit_q, hit_d;
  logic [IDX_W-1:0] hidx_q, hidx_d;
  logic [47:0] hmac_q, hmac_d;
  logic        free_q, free_d;
  logic [IDX_W-1:0] fidx_q, fidx_d;
  logic [7:0]  old_q, old_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic [7:0]  age_q, age_d;
  out_item_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        tgt_local, dst_local;
  logic [7:0]  age_v;

  assign tgt_local = (in_data_i.target_ip & cfg_i.subnet_mask) ==
                     (cfg_i.subnet_addr & cfg_i.subnet_mask);
  assign dst_local = (in_data_i.dest_ip & cfg_i.subnet_mask) ==
                     (cfg_i.subnet_addr & cfg_i.subnet_mask);
  assign age_v     = age_q - rd_data_i.stamp;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd_en_o   = (state_q == ST_SCAN) && (issue_q != LAST_CNT);
  assign rd_addr_o = issue_q[IDX_W-1:0];
  assign wr_en_o   = (state_q == ST_WRITE);
  assign wr_addr_o = hit_q ? hidx_q : (free_q ? fidx_q : oidx_q);
  assign wr_data_o = '{ip: key_q, mac: smac_q, stamp: age_q};

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    smac_d      = smac_q;
    upd_d       = upd_q;
    rep_d       = rep_q;
    issue_d     = issue_q;
    rdv_d       = 1'b0;
    ridx_d      = ridx_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    hmac_d      = hmac_q;
    free_d      = free_q;
    fidx_d      = fidx_q;
    old_d       = old_q;
    oidx_d      = oidx_q;
    age_d       = age_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_data_i.sender_ip;
          smac_d  = in_data_i.sender_mac;
          upd_d   = 1'b0;
          rep_d   = 1'b0;
          issue_d = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          old_d   = '0;
          oidx_d  = '0;
          res_d   = '{action: ACT_NONE, dest_mac: '0, request_ip: '0};
          state_d = ST_RESP;
          case (in_data_i.func)
            FUNC_RX: begin
              if (in_data_i.frame_type == ETYPE_ARP) begin
                if (tgt_local && (in_data_i.arp_opcode == OP_REQUEST ||
                                  in_data_i.arp_opcode == OP_REPLY)) begin
                  upd_d   = 1'b1;
                  rep_d   = (in_data_i.arp_opcode == OP_REQUEST);
                  state_d = ST_SCAN;
                end
              end else if (in_data_i.frame_type == ETYPE_IP) begin
                res_d.action = ACT_DELIVER;
              end
            end
            FUNC_RESOLVE: begin
              if (in_data_i.dest_ip == BCAST_IP) begin
                res_d = '{action: ACT_SEND, dest_mac: BCAST_MAC, request_ip: '0};
              end else begin
                key_d   = dst_local ? in_data_i.dest_ip : cfg_i.router_ip;
                state_d = ST_SCAN;
              end
            end
            FUNC_TICK: begin
              age_d = age_q + 8'd1;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_en_o) begin
          issue_d = issue_q + 1'b1;
          rdv_d   = 1'b1;
          ridx_d  = issue_q[IDX_W-1:0];
        end
        if (rdv_q) begin
          if (!hit_q && rd_data_i.ip != '0 && rd_data_i.ip == key_q) begin
            hit_d  = 1'b1;
            hidx_d = ridx_q;
            hmac_d = rd_data_i.mac;
          end
          if (!free_q && rd_data_i.ip == '0) begin
            free_d = 1'b1;
            fidx_d = ridx_q;
          end
          if (age_v > old_q) begin
            old_d  = age_v;
            oidx_d = ridx_q;
          end
        end
        if (issue_q == LAST_CNT && !rdv_q) begin
          if (upd_q) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_RESP;
            if (hit_q) begin
              res_d = '{action: ACT_SEND, dest_mac: hmac_q, request_ip: '0};
            end else begin
              res_d = '{action: ACT_REQUEST, dest_mac: BCAST_MAC, request_ip: key_q};
            end
          end
        end
      end

      ST_WRITE: begin
        if (rep_q) begin
          res_d = '{action: ACT_REPLY, dest_mac: smac_q, request_ip: key_q};
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_q       <= '0;
      smac_q      <= '0;
      upd_q       <= 1'b0;
      rep_q       <= 1'b0;
      issue_q     <= '0;
      rdv_q       <= 1'b0;
      ridx_q      <= '0;
      hit_q       <= 1'b0;
      hidx_q      <= '0;
      hmac_q      <= '0;
      free_q      <= 1'b0;
      fidx_q      <= '0;
      old_q       <= '0;
      oidx_q      <= '0;
      age_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      smac_q      <= smac_d;
      upd_q       <= upd_d;
      rep_q       <= rep_d;
      issue_q     <= issue_d;
      rdv_q       <= rdv_d;
      ridx_q      <= ridx_d;
      hit_q       <= hit_d;
      hidx_q      <= hidx_d;
      hmac_q      <= hmac_d;
      free_q      <= free_d;
      fidx_q      <= fidx_d;
      old_q       <= old_d;
      oidx_q      <= oidx_d;
      age_q       <= age_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // one transaction in flight
  a_single_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a transaction is in flight");

  // table write only on an update, and never while reads are pending
  a_wr_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (upd_q && !rdv_q && !rd_en_o))
    else $error("table write outside an update");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (32'(wr_addr_o) < TABLE_ENTRIES))
    else $error("table write beyond last entry");

  // ARP requests always go to the broadcast address
  a_req_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == ACT_REQUEST) |-> (out_data_o.dest_mac == BCAST_MAC))
    else $error("ARP request without broadcast destination");

endmodule
`default_nettype wire

// ===== hdl/arp_cache_resolver.sv =====
// Top level of the ARP cache resolver: register file, sequencer and entry memory.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  input   | in        | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//  output  | out       | out_valid_o/out_ready_i | out_data_o (out_item_t)
//  config  | in/out    | psel, penable, pready   | paddr, pwdata, prdata
//
// Scan: a transaction that needs the table (ARP request/reply on the
//   subnet, non-broadcast resolve) reads one entry per cycle, then waits for
//   the last read to return; an update then writes back in ST_WRITE. All
//   other transactions go straight to ST_RESP. One transaction is worked at
//   a time.
// Reset: per-entry valid bits clear the table at once; unwritten entries read
//   as free (all zero). No clearing pass.
// Stalls: the result sits in an output register, so the next transaction is
//   accepted while it waits; a new result waits for that register to empty.
`default_nettype none
module arp_cache_resolver
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // index into the table; counter sized by $clog2(TABLE_ENTRIES + 1) so it can hold the depth
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  cfg_t             cfg;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;

  arpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: decode, scan for match / free / oldest, write back, respond
  arpc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // IP, MAC and stamp of each entry in one word
  arpc_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule
`default_nettype wire
